@@ src/dacc_pkg.sv @@
// ----------------------------------------------------------------------------
// dacc_pkg
// types, codes and decimal helpers shared by the accumulator machine
// ----------------------------------------------------------------------------
`default_nettype none

package dacc_pkg;

  localparam int CMD_W  = 2;
  localparam int ADDR_W = 10;
  localparam int WORD_W = 14;
  localparam int OP_W   = 4;

  // store depth, tied to the three-digit address field
  localparam int MEM_WORDS = 1000;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  // opcode digits
  localparam logic [OP_W-1:0] OP_HLT = 4'd0;
  localparam logic [OP_W-1:0] OP_LOD = 4'd1;
  localparam logic [OP_W-1:0] OP_STO = 4'd2;
  localparam logic [OP_W-1:0] OP_ADD = 4'd3;
  localparam logic [OP_W-1:0] OP_SUB = 4'd4;
  localparam logic [OP_W-1:0] OP_JMP = 4'd5;
  localparam logic [OP_W-1:0] OP_JEQ = 4'd6;
  localparam logic [OP_W-1:0] OP_JGE = 4'd7;
  localparam logic [OP_W-1:0] OP_JGT = 4'd8;
  localparam logic [OP_W-1:0] OP_DSZ = 4'd9;

  localparam logic [WORD_W-1:0] WORD_MOD = 14'd10000;
  localparam logic [WORD_W-1:0] WORD_MAX = 14'd9999;

  localparam logic [ADDR_W-1:0] KEYPAD_ADDR  = 10'd998;
  localparam logic [ADDR_W-1:0] DISPLAY_ADDR = 10'd999;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] keypad_value;
  } request_t;

  typedef struct packed {
    logic              halted;
    logic [ADDR_W-1:0] prog_counter;
    logic [WORD_W-1:0] accumulator;
    logic              display_valid;
    logic [WORD_W-1:0] display_value;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] where;
  } instr_t;

  // 14-bit field is below twice the modulus, so one compare and subtract
  function automatic logic [WORD_W-1:0] mod_word(input logic [WORD_W-1:0] v);
    mod_word = (v >= WORD_MOD) ? v - WORD_MOD : v;
  endfunction

  function automatic logic [WORD_W-1:0] thousands(input logic [OP_W-1:0] d);
    logic [WORD_W-1:0] t;
    case (d)
      4'd1:    t = 14'd1000;
      4'd2:    t = 14'd2000;
      4'd3:    t = 14'd3000;
      4'd4:    t = 14'd4000;
      4'd5:    t = 14'd5000;
      4'd6:    t = 14'd6000;
      4'd7:    t = 14'd7000;
      4'd8:    t = 14'd8000;
      4'd9:    t = 14'd9000;
      default: t = 14'd0;
    endcase
    thousands = t;
  endfunction

  // opcode digit from nine parallel threshold compares, address is the rest
  function automatic instr_t split_word(input logic [WORD_W-1:0] w);
    instr_t            r;
    logic [WORD_W-1:0] rest;
    r.op = OP_HLT;
    for (int i = 1; i < 10; i++) begin
      if (w >= thousands(OP_W'(i))) r.op = OP_W'(i);
    end
    rest    = w - thousands(r.op);
    r.where = rest[ADDR_W-1:0];
    split_word = r;
  endfunction

endpackage

`default_nettype wire

@@ src/dacc_ram.sv @@
// ----------------------------------------------------------------------------
// dacc_ram
// single-port synchronous ram, one write and one registered read per cycle, on one address
// ----------------------------------------------------------------------------
`default_nettype none

module dacc_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 1000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ src/decimal_accumulator_cpu_step.sv @@
// ----------------------------------------------------------------------------
// decimal_accumulator_cpu_step
// decimal accumulator machine: store load, single step and restart commands
// ----------------------------------------------------------------------------
// usage
//   a request is taken at a rising edge with start high and busy low; cmd
//   selects a store write, one instruction step or a restart
//   every request gives one result on the result port, marked by done for
//   exactly one cycle; the receiver cannot stall it
//   write, restart, unused command and step while halted: done in the cycle
//   after the request, busy stays low so back-to-back requests go in
//   step: the request cycle reads the instruction word, the fetch cycle
//   decodes it and reads the operand, the execute cycle computes and
//   writes back; busy is high in fetch and execute and done follows the
//   execute cycle
//   the step is split this way because the word store has a single port:
//   instruction read, operand read and write-back each need an access
//   reset clears pc, accumulator, halt flag and the sequencer; the word
//   store keeps whatever it held and is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_accumulator_cpu_step
  import dacc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire request_t request,
  output logic          done,
  output result_t       result
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_WORDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  // control state
  state_t            state;
  logic [ADDR_W-1:0] pc;
  logic [WORD_W-1:0] acc;
  logic              halt;

  // per-step payload, held from request to execute
  logic [WORD_W-1:0] keypad;
  logic [ADDR_W-1:0] pc_inc;
  instr_t            instr;

  // store port
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic              accept;
  logic              step_go;
  instr_t            fetched;
  logic [WORD_W-1:0] m_dec;
  logic [WORD_W:0]   add_sum;
  logic [ADDR_W-1:0] pc_skip;

  logic [ADDR_W-1:0] exec_pc;
  logic [WORD_W-1:0] exec_acc;
  logic              exec_halt;
  logic              exec_disp;
  result_t           result_next;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign step_go = accept && (request.cmd == CMD_STEP) && !halt;

  // the word read at pc arrives in the fetch cycle
  assign fetched = split_word(ram_rdata);

  dacc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // store port steering: write command or instruction read at pc in idle,
  // operand read in fetch, write-back of sto and dsz in execute
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = AW'(pc);
    ram_wdata = acc;
    unique case (state)
      ST_IDLE: begin
        if (accept && (request.cmd == CMD_WRITE)) begin
          ram_addr  = AW'(request.address);
          ram_wdata = mod_word(request.value);
          ram_we    = (request.address < LAST_ADDR) || (request.address == LAST_ADDR);
        end
      end
      ST_FETCH: begin
        ram_addr = AW'(fetched.where);
      end
      ST_EXEC: begin
        ram_addr = AW'(instr.where);
        if (instr.op == OP_STO) begin
          ram_we    = 1'b1;
          ram_wdata = acc;
        end else if (instr.op == OP_DSZ) begin
          ram_we    = 1'b1;
          ram_wdata = m_dec;
        end
      end
      default: ;
    endcase
  end

  // execute: operand word is on ram_rdata
  assign m_dec   = (ram_rdata == '0) ? WORD_MAX : ram_rdata - 1'b1;
  assign add_sum = {1'b0, acc} + {1'b0, ram_rdata};
  assign pc_skip = (pc_inc == LAST_ADDR) ? '0 : pc_inc + 1'b1;

  always_comb begin
    exec_pc   = pc_inc;
    exec_acc  = acc;
    exec_halt = halt;
    exec_disp = 1'b0;
    case (instr.op)
      OP_HLT: exec_halt = 1'b1;
      OP_LOD: exec_acc  = (instr.where == KEYPAD_ADDR) ? keypad : ram_rdata;
      OP_STO: exec_disp = (instr.where == DISPLAY_ADDR);
      OP_ADD: begin
        exec_acc = (add_sum >= {1'b0, WORD_MOD}) ? WORD_W'(add_sum - {1'b0, WORD_MOD})
                                                  : add_sum[WORD_W-1:0];
      end
      OP_SUB: begin
        exec_acc = (acc >= ram_rdata) ? acc - ram_rdata : acc + (WORD_MOD - ram_rdata);
      end
      OP_JMP: exec_pc = instr.where;
      OP_JEQ: if (acc == '0) exec_pc = instr.where;
      OP_JGE: exec_pc = instr.where;
      OP_JGT: if (acc != '0) exec_pc = instr.where;
      OP_DSZ: if (m_dec == '0) exec_pc = pc_skip;
      default: ;
    endcase
  end

  // result word for the cycle that raises done
  always_comb begin
    result_next.halted        = halt;
    result_next.prog_counter  = pc;
    result_next.accumulator   = acc;
    result_next.display_valid = 1'b0;
    result_next.display_value = '0;
    if (state == ST_EXEC) begin
      result_next.halted        = exec_halt;
      result_next.prog_counter  = exec_pc;
      result_next.accumulator   = exec_acc;
      result_next.display_valid = exec_disp;
      result_next.display_value = exec_disp ? acc : '0;
    end else if (request.cmd == CMD_RESTART) begin
      result_next.halted       = 1'b0;
      result_next.prog_counter = '0;
      result_next.accumulator  = '0;
    end
  end

  // sequencer and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
      acc   <= '0;
      halt  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (step_go) begin
            state <= ST_FETCH;
          end else if (accept) begin
            done <= 1'b1;
            if (request.cmd == CMD_RESTART) begin
              pc   <= '0;
              acc  <= '0;
              halt <= 1'b0;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          pc    <= exec_pc;
          acc   <= exec_acc;
          halt  <= exec_halt;
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (step_go) begin
      keypad <= mod_word(request.keypad_value);
      pc_inc <= (pc == LAST_ADDR) ? '0 : pc + 1'b1;
    end
    if (state == ST_FETCH) begin
      instr <= fetched;
    end
    result <= result_next;
  end

endmodule

`default_nettype wire

@@ src/dacc_checker.sv @@
// ----------------------------------------------------------------------------
// dacc_checker
// port-level checks on the request and result timing and the display output of the machine
// ----------------------------------------------------------------------------
`default_nettype none

module dacc_checker
  import dacc_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire request_t request,
  input wire logic     done,
  input wire result_t  result
);

  // a result never appears while a step is still in flight
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    !(done && busy))
    else $error("result strobe while busy");

  // every request either answers next cycle or starts a step
  a_req_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("request neither answered nor started");

  // a step holds busy for fetch and execute, then answers
  a_step_len: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ##1 busy ##1 (!busy && done))
    else $error("step did not finish in three cycles");

  // the display shows the accumulator, and nothing when not written
  a_disp_value: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.display_valid ? (result.display_value == result.accumulator)
                                   : (result.display_value == '0)))
    else $error("display value inconsistent");

  // the display strobe only rides on a result
  a_disp_strobe: assert property (@(posedge clk) disable iff (rst)
    result.display_valid |-> done)
    else $error("display strobe without a result");

endmodule

bind decimal_accumulator_cpu_step dacc_checker u_checker (.*);

`default_nettype wire
